// ===== rtl/mrar_pkg.sv =====
// Shared types, constants and the sine/cosine table generator for the
// matrix row axis rotation core. No dependencies.
`default_nettype none

package mrar_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int ELEM_W     = 32;
	localparam int OFS_BITS   = ANGLE_BITS - 2;
	localparam int ROM_DEPTH  = 1 << OFS_BITS;
	localparam int TRIG_W     = 16;
	localparam int FRAC       = 15;
	localparam int PROD_W     = ELEM_W + TRIG_W;
	localparam int RES_W      = PROD_W - FRAC;
	localparam int SUM_W      = RES_W + 1;

	localparam logic [63:0] PI_Q40  = 64'h0000_0324_3F6A_8885;
	localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [ANGLE_BITS-1:0] turn_angle;
		elem_t                 elem_x;
		elem_t                 elem_y;
		elem_t                 elem_z;
		elem_t                 elem_w;
	} req_t;

	typedef struct packed {
		elem_t out_x;
		elem_t out_y;
		elem_t out_z;
		elem_t out_w;
	} res_t;

	// Row as it sits in the input stage
	typedef struct packed {
		axis_t      cmd;
		logic [1:0] quad;
		elem_t      x;
		elem_t      y;
		elem_t      z;
		elem_t      w;
	} pipe_t;

	// Unsigned Q1.15 magnitudes of sine and cosine in the first quadrant
	typedef struct packed {
		logic [TRIG_W-1:0] sin_mag;
		logic [TRIG_W-1:0] cos_mag;
	} trig_mag_t;

	// Row plus the four raw products of the rotation
	typedef struct packed {
		axis_t                     cmd;
		elem_t                     x;
		elem_t                     y;
		elem_t                     z;
		elem_t                     w;
		logic signed [PROD_W-1:0]  uc;
		logic signed [PROD_W-1:0]  vs;
		logic signed [PROD_W-1:0]  us;
		logic signed [PROD_W-1:0]  vc;
	} prod_t;

	// Table entry for quadrant offset r: series evaluation in Q30, rounded to Q1.15.
	// Evaluated only with constant arguments, while the table is built.
	function automatic trig_mag_t trig_entry(input int unsigned r);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] ps_r;
		logic [63:0] pc_r;
		longint      sum;
		longint      ps;
		longint      pc;
		t = (64'(r) * PI_Q40 + (64'd1 << (ANGLE_BITS + 8))) >> (ANGLE_BITS + 9);
		t2 = (t * t + (Q30_ONE >> 1)) >> 30;
		// sine: each step divides by (2k)(2k+1)
		term = t;
		sum = longint'(t);
		term = ((term * t2) >> 30) / 64'd6;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd20;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd42;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd72;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd110;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd156;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd210;
		sum = sum - longint'(term);
		ps = (sum < 0) ? 64'sd0 : sum;
		// cosine: each step divides by (2k-1)(2k)
		term = Q30_ONE;
		sum = longint'(Q30_ONE);
		term = ((term * t2) >> 30) / 64'd2;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd12;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd30;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd56;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd90;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd132;
		sum = sum + longint'(term);
		term = ((term * t2) >> 30) / 64'd182;
		sum = sum - longint'(term);
		term = ((term * t2) >> 30) / 64'd240;
		sum = sum + longint'(term);
		pc = (sum < 0) ? 64'sd0 : sum;
		ps_r = (64'(ps) + 64'd16384) >> FRAC;
		pc_r = (64'(pc) + 64'd16384) >> FRAC;
		return '{sin_mag: ps_r[TRIG_W-1:0], cos_mag: pc_r[TRIG_W-1:0]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mrar_sincos_rom.sv =====
// Sine/cosine magnitude table with registered read.
// Depends on mrar_pkg (table generator and entry type).
`default_nettype none

module mrar_sincos_rom import mrar_pkg::*; (
	input  wire logic                clk,
	input  wire logic                rd_en,
	input  wire logic [OFS_BITS-1:0] addr,
	output trig_mag_t                mag_q
);

	trig_mag_t rom [ROM_DEPTH];

	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		localparam trig_mag_t ENTRY = trig_entry(i);
		assign rom[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mag_q <= rom[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mrar_mul_stage.sv =====
// Quadrant folding of sine/cosine and the four rotation products.
// Depends on mrar_pkg.
`default_nettype none

module mrar_mul_stage import mrar_pkg::*; (
	input  wire pipe_t     row,
	input  wire trig_mag_t mag,
	output prod_t          prod
);

	localparam logic [TRIG_W-1:0] POS_MAX = {1'b0, {(TRIG_W-1){1'b1}}};

	logic signed [TRIG_W-1:0] ps_pos, pc_pos, ps_neg, pc_neg;
	logic signed [TRIG_W-1:0] sin_v, cos_v;
	elem_t                    u, v;

	// clip +1.0 to the largest positive code; -1.0 is representable
	assign ps_pos = (mag.sin_mag > POS_MAX) ? POS_MAX : mag.sin_mag;
	assign pc_pos = (mag.cos_mag > POS_MAX) ? POS_MAX : mag.cos_mag;
	assign ps_neg = TRIG_W'(~mag.sin_mag + 1'b1);
	assign pc_neg = TRIG_W'(~mag.cos_mag + 1'b1);

	always_comb begin
		case (row.quad)
			2'd0: begin
				sin_v = ps_pos;
				cos_v = pc_pos;
			end
			2'd1: begin
				sin_v = pc_pos;
				cos_v = ps_neg;
			end
			2'd2: begin
				sin_v = ps_neg;
				cos_v = pc_neg;
			end
			default: begin
				sin_v = pc_neg;
				cos_v = ps_pos;
			end
		endcase
	end

	// every axis reduces to u' = u*c - v*s, v' = u*s + v*c
	always_comb begin
		case (row.cmd)
			AXIS_X: begin
				u = row.y;
				v = row.z;
			end
			AXIS_Y: begin
				u = row.z;
				v = row.x;
			end
			default: begin
				u = row.x;
				v = row.y;
			end
		endcase
	end

	always_comb begin
		prod.cmd = row.cmd;
		prod.x   = row.x;
		prod.y   = row.y;
		prod.z   = row.z;
		prod.w   = row.w;
		prod.uc  = PROD_W'(u) * PROD_W'(cos_v);
		prod.vs  = PROD_W'(v) * PROD_W'(sin_v);
		prod.us  = PROD_W'(u) * PROD_W'(sin_v);
		prod.vc  = PROD_W'(v) * PROD_W'(cos_v);
	end

endmodule

`default_nettype wire

// ===== rtl/mrar_sum_stage.sv =====
// Rounding, summing and saturation of the rotation products; row reassembly.
// Depends on mrar_pkg.
`default_nettype none

module mrar_sum_stage import mrar_pkg::*; (
	input  wire prod_t prod,
	output res_t       res
);

	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC - 1);

	function automatic logic signed [RES_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + HALF;
		return RES_W'(t >>> FRAC);
	endfunction

	function automatic elem_t sat_elem(input logic signed [SUM_W-1:0] s);
		logic ovf;
		ovf = (s[SUM_W-1:ELEM_W-1] != {(SUM_W-ELEM_W+1){1'b0}}) &&
		      (s[SUM_W-1:ELEM_W-1] != {(SUM_W-ELEM_W+1){1'b1}});
		if (!ovf) return s[ELEM_W-1:0];
		else if (s[SUM_W-1]) return {1'b1, {(ELEM_W-1){1'b0}}};
		else return {1'b0, {(ELEM_W-1){1'b1}}};
	endfunction

	logic signed [SUM_W-1:0] r0, r1;
	elem_t                   u_new, v_new;

	assign r0    = SUM_W'(round_q15(prod.uc)) - SUM_W'(round_q15(prod.vs));
	assign r1    = SUM_W'(round_q15(prod.us)) + SUM_W'(round_q15(prod.vc));
	assign u_new = sat_elem(r0);
	assign v_new = sat_elem(r1);

	always_comb begin
		res.out_x = prod.x;
		res.out_y = prod.y;
		res.out_z = prod.z;
		res.out_w = prod.w;
		case (prod.cmd)
			AXIS_X: begin
				res.out_y = u_new;
				res.out_z = v_new;
			end
			AXIS_Y: begin
				res.out_z = u_new;
				res.out_x = v_new;
			end
			AXIS_Z: begin
				res.out_x = u_new;
				res.out_y = v_new;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/matrix_row_axis_rotate_core.sv =====
// Matrix row axis rotation core: rotates one (x, y, z, w) row about x, y or z.
// An accepted request moves through the input register and then the result register.
// Throughput: one request per cycle unless res_stall holds a valid result; a stalled result
// holds the result register, and the input register (row plus table read) too when it is full.
// Reset: arst_n clears the stage valid flags asynchronously; data registers hold.
// Depends on mrar_pkg, mrar_sincos_rom, mrar_mul_stage, mrar_sum_stage.
`default_nettype none

module matrix_row_axis_rotate_core import mrar_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_data,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res_data
);

	// Stage enables: a stage loads when it is empty or its successor moves,
	// so bubbles collapse and requests keep entering while a result waits.
	logic en1, en2;
	logic v1_s1, v2_s2;

	pipe_t     row_s1;
	trig_mag_t mag_s1;
	prod_t     prod_c;
	res_t      res_c;

	assign en2 = !v2_s2 || !res_stall;
	assign en1 = !v1_s1 || en2;

	assign req_stall = !en1;
	assign res_valid = v2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= req_valid;
			if (en2) v2_s2 <= v1_s1;
		end
	end

	// Stage 1: capture the request and its quadrant; read the table by offset
	always_ff @(posedge clk) begin
		if (en1) begin
			row_s1.cmd  <= axis_t'(req_data.cmd);
			row_s1.quad <= req_data.turn_angle[ANGLE_BITS-1 -: 2];
			row_s1.x    <= req_data.elem_x;
			row_s1.y    <= req_data.elem_y;
			row_s1.z    <= req_data.elem_z;
			row_s1.w    <= req_data.elem_w;
		end
	end

	mrar_sincos_rom u_rom (
		.clk   (clk),
		.rd_en (en1),
		.addr  (req_data.turn_angle[OFS_BITS-1:0]),
		.mag_q (mag_s1)
	);

	// Stage 2: fold the quadrant, form the products, then round, sum and
	// saturate into the output register; hold while stalled
	mrar_mul_stage u_mul (
		.row  (row_s1),
		.mag  (mag_s1),
		.prod (prod_c)
	);

	mrar_sum_stage u_sum (
		.prod (prod_c),
		.res  (res_c)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			res_data <= res_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mrar_checker.sv =====
// Port-level checks for matrix_row_axis_rotate_core, bound to the top level.
// Depends on mrar_pkg and matrix_row_axis_rotate_core.
`default_nettype none

module mrar_checker import mrar_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req_data,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_t res_data
);

	// a result held back must stay valid
	a_res_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// a result held back must not change
	a_res_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_data))
		else $error("result changed while stalled");

	// an idle output side never pushes back on requests
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled with empty output");

	// w passes through unchanged when nothing stalls
	a_w_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) ##1 !res_stall
		|=> res_valid && (res_data.out_w == $past(req_data.elem_w, 2)))
		else $error("w element lost or late");

	// x is untouched by an x-axis rotation or no rotation
	a_x_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall &&
		 ((req_data.cmd == AXIS_X) || (req_data.cmd == AXIS_NONE)))
		##1 !res_stall
		|=> res_valid && (res_data.out_x == $past(req_data.elem_x, 2)))
		else $error("x element altered");

endmodule

bind matrix_row_axis_rotate_core mrar_checker u_mrar_checker (.*);

`default_nettype wire
